[rtl/lrp_pkg.sv]
package lrp_pkg;

	localparam int MAX_ORDER   = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int COEFF_W     = 16;
	localparam int ACC_W       = 32;
	localparam int PROD_W      = COEFF_W + SAMPLE_BITS;
	localparam int IDX_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CNT_W       = $clog2(MAX_ORDER + 1);
	localparam int CMD_W       = 2;
	localparam int ORDER_W     = 6;
	localparam int SHIFT_W     = 5;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WARM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESID = 2'd2;

	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_SHIFT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic vld;
		logic hvalid;
	} mac_ctrl_t;

endpackage

[rtl/lpc_residual_predictor_core.sv]
// Linear-prediction residual engine. Load and warm-up transactions are taken in the idle
// state and complete there; a residual transaction runs from acceptance to the result register,
// over taps, taps being filter_order capped at 32. The single shared multiply-accumulate
// walks the coefficient RAM and the circular sample-history RAM one tap per cycle, through
// the RAM read and product register stages.
// A result waits in an output register; loads and warm-ups are taken meanwhile, and a
// further residual stalls at its end until the waiting result is taken. History reads as
// zero after reset through per-entry valid flops; coefficients are undefined until loaded.
module lpc_residual_predictor_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lrp_pkg::PADDR_W-1:0]          paddr,
	input  logic [lrp_pkg::PDATA_W-1:0]          pwdata,
	output logic [lrp_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lrp_pkg::CMD_W-1:0]            command,
	input  logic [4:0]                           coeff_index,
	input  logic signed [lrp_pkg::COEFF_W-1:0]     coeff_value,
	input  logic signed [15:0]                   sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lrp_pkg::ACC_W-1:0]       residual
);

	localparam int IW = lrp_pkg::IDX_W;

	lrp_pkg::state_t                    state_q, state_d;
	logic [lrp_pkg::ORDER_W-1:0]        order_q;
	logic [lrp_pkg::SHIFT_W-1:0]        shift_q;
	logic [lrp_pkg::CNT_W-1:0]          cnt_q;
	logic [lrp_pkg::CNT_W-1:0]          taps;
	logic [IW-1:0]                      head_q, head_nxt;
	logic [lrp_pkg::MAX_ORDER-1:0]      hvalid_q;
	logic                               iss_s1, hv_s1;
	logic                               out_valid_q;
	logic signed [lrp_pkg::ACC_W-1:0]     smp_q, res_q, smp_in;
	logic                               accept, cfg_we;
	logic                               iss, acc_clr, push, fin_go, coeff_we;
	logic [IW-1:0]                      tap_j, hist_raddr;
	logic [IW:0]                        addr_wrap;
	logic [lrp_pkg::SAMPLE_BITS-1:0]    hist_wdata, hist_rdata;
	logic [lrp_pkg::COEFF_W-1:0]        coeff_rdata;
	lrp_pkg::mac_ctrl_t                 mac_ctrl;
	logic                               mac_busy;
	logic [lrp_pkg::ACC_W-1:0]          acc;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= lrp_pkg::ORDER_W'(1);
			shift_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[2])
				lrp_pkg::REG_ORDER: order_q <= pwdata[lrp_pkg::ORDER_W-1:0];
				lrp_pkg::REG_SHIFT: shift_q <= pwdata[lrp_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lrp_pkg::REG_ORDER: prdata = lrp_pkg::PDATA_W'(order_q);
			lrp_pkg::REG_SHIFT: prdata = lrp_pkg::PDATA_W'(shift_q);
			default:            prdata = '0;
		endcase
	end

	assign taps = (7'(order_q) > 7'(lrp_pkg::MAX_ORDER)) ?
		lrp_pkg::CNT_W'(lrp_pkg::MAX_ORDER) : lrp_pkg::CNT_W'(order_q);

	assign accept   = in_valid && in_ready;
	assign smp_in   = lrp_pkg::ACC_W'(signed'(sample[lrp_pkg::SAMPLE_BITS-1:0]));
	assign head_nxt = (32'(head_q) == lrp_pkg::MAX_ORDER - 1) ? '0 : head_q + IW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				if (accept && command == lrp_pkg::CMD_RESID) begin
					state_d = lrp_pkg::ST_RUN;
				end
			end
			lrp_pkg::ST_RUN: begin
				if (!iss && !iss_s1 && !mac_busy) begin
					state_d = lrp_pkg::ST_FIN;
				end
			end
			lrp_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = lrp_pkg::ST_IDLE;
				end
			end
			default: state_d = lrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		iss      = 1'b0;
		acc_clr  = 1'b0;
		push     = 1'b0;
		fin_go   = 1'b0;
		coeff_we = 1'b0;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (command)
						lrp_pkg::CMD_LOAD:
							coeff_we = (6'(coeff_index) < 6'(lrp_pkg::MAX_ORDER));
						lrp_pkg::CMD_WARM:  push    = 1'b1;
						lrp_pkg::CMD_RESID: acc_clr = 1'b1;
						default: ;
					endcase
				end
			end
			lrp_pkg::ST_RUN: begin
				iss = (cnt_q < taps);
			end
			lrp_pkg::ST_FIN: begin
				fin_go = !out_valid_q || out_ready;
				push   = fin_go;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrp_pkg::ST_IDLE;
			cnt_q       <= '0;
			head_q      <= '0;
			hvalid_q    <= '0;
			iss_s1      <= 1'b0;
			hv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_s1  <= iss;
			hv_s1   <= hvalid_q[hist_raddr];
			if (acc_clr) begin
				cnt_q <= '0;
			end else if (iss) begin
				cnt_q <= cnt_q + lrp_pkg::CNT_W'(1);
			end
			if (push) begin
				head_q             <= head_nxt;
				hvalid_q[head_nxt] <= 1'b1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			smp_q <= smp_in;
		end
		if (fin_go) begin
			res_q <= smp_q - (signed'(acc) >>> shift_q);
		end
	end

	assign tap_j = cnt_q[IW-1:0];

	always_comb begin
		if (head_q >= tap_j) begin
			addr_wrap = (IW+1)'(head_q) - (IW+1)'(tap_j);
		end else begin
			addr_wrap = (IW+1)'(head_q) + (IW+1)'(lrp_pkg::MAX_ORDER) - (IW+1)'(tap_j);
		end
		hist_raddr = addr_wrap[IW-1:0];
	end

	assign hist_wdata = (state_q == lrp_pkg::ST_FIN) ?
		smp_q[lrp_pkg::SAMPLE_BITS-1:0] : sample[lrp_pkg::SAMPLE_BITS-1:0];

	lrp_ram #(
		.WIDTH(lrp_pkg::SAMPLE_BITS),
		.DEPTH(lrp_pkg::MAX_ORDER)
	) u_hist_ram (
		.clk  (clk),
		.we   (push),
		.waddr(head_nxt),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	lrp_ram #(
		.WIDTH(lrp_pkg::COEFF_W),
		.DEPTH(lrp_pkg::MAX_ORDER)
	) u_coeff_ram (
		.clk  (clk),
		.we   (coeff_we),
		.waddr(coeff_index[IW-1:0]),
		.wdata(coeff_value),
		.raddr(tap_j),
		.rdata(coeff_rdata)
	);

	assign mac_ctrl.clear  = acc_clr;
	assign mac_ctrl.vld    = iss_s1;
	assign mac_ctrl.hvalid = hv_s1;

	lrp_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.coeff (signed'(coeff_rdata)),
		.hist  (signed'(hist_rdata)),
		.busy  (mac_busy),
		.acc   (acc)
	);

	assign out_valid = out_valid_q;
	assign residual  = res_q;

	a_fin_all_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrp_pkg::ST_FIN) |-> (cnt_q == taps))
		else $error("residual finished before all taps were issued");

	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lrp_pkg::ST_RUN) |-> (!iss_s1 && !mac_busy))
		else $error("multiply-accumulate busy outside run state");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lrp_pkg::ST_FIN))
		else $error("result raised without a finished residual");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!iss_s1 && !mac_busy && !iss))
		else $error("history written while taps in flight");

endmodule

[rtl/lrp_ram.sv]
module lrp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/lrp_mac.sv]
module lrp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lrp_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [lrp_pkg::COEFF_W-1:0]     coeff,
	input  logic signed [lrp_pkg::SAMPLE_BITS-1:0] hist,
	output logic                                 busy,
	output logic [lrp_pkg::ACC_W-1:0]            acc
);

	logic                               vld_s2;
	logic signed [lrp_pkg::PROD_W-1:0]  prod_s2;
	logic signed [lrp_pkg::PROD_W-1:0]  prod_d;
	logic [lrp_pkg::ACC_W-1:0]          acc_q;

	always_comb begin
		prod_d = '0;
		if (ctrl.hvalid) begin
			prod_d = coeff * hist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctrl.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_d;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + lrp_pkg::ACC_W'(prod_s2);
		end
	end

	assign busy = vld_s2;
	assign acc  = acc_q;

endmodule
